FILE: src/spsg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsg_pkg
// Types, constants and helpers shared by the serial password session guard.
// ----------------------------------------------------------------------------
package spsg_pkg;

	// command store geometry
	localparam int BUFFER_DEPTH = 32;
	localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
	localparam int KEY_BYTES    = 8;
	// common width for comparing store positions against key lengths
	localparam int CNT_W        = (ADDR_W > 4) ? ADDR_W : 4;

	// characters and command codes
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CMD_START  = 8'h49;
	localparam logic [7:0] CMD_REPLY  = 8'h52;
	localparam logic [7:0] CMD_LOGOUT = 8'h4F;

	// register reset values
	localparam logic [31:0] SESSION_LIMIT_RST = 32'd300000;
	localparam logic [31:0] AUTH_TIMEOUT_RST  = 32'd10000;
	localparam logic [63:0] PASSWORD_KEY_RST  = 64'h5365_6C65_7831_3233;
	localparam logic [3:0]  KEY_LENGTH_RST    = 4'd8;

	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_NOT_REG = 2'd0,
		ST_PROCESS = 2'd1,
		ST_PASS    = 2'd2,
		ST_FAIL    = 2'd3
	} guard_state_t;

	typedef enum logic [1:0] {
		RSP_NONE = 2'd0,
		RSP_OK   = 2'd1,
		RSP_ERR  = 2'd2
	} rsp_t;

	typedef enum logic [1:0] {
		CFG_SESSION_LIMIT = 2'd0,
		CFG_AUTH_TIMEOUT  = 2'd1,
		CFG_PASSWORD_KEY  = 2'd2,
		CFG_KEY_LENGTH    = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		SQ_IDLE,
		SQ_T_ADD,
		SQ_T_CMP,
		SQ_CHK,
		SQ_RD_CR,
		SQ_RD_LF,
		SQ_RD_CMD,
		SQ_PW,
		SQ_FINISH
	} seq_state_t;

	typedef struct packed {
		logic [31:0] session_limit;
		logic [31:0] auth_timeout;
		logic [63:0] password_key;
		logic [3:0]  key_length;
	} cfg_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  byte_value;
		logic [15:0] elapsed_ms;
	} item_t;

	typedef struct packed {
		logic         valid;
		rsp_t         response;
		guard_state_t auth_state;
	} res_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [31:0] sum_sat;
		logic        ge;
		logic        eq;
	} alu_rsp_t;

	// key character i, first character in the top byte
	function automatic logic [7:0] key_char(input logic [63:0] key, input logic [2:0] i);
		logic [5:0] sh;
		sh = {3'(3'd7 - i), 3'b000};
		return key[sh +: 8];
	endfunction

endpackage

FILE: src/spsg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsg_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface spsg_in_if;
	import spsg_pkg::*;

	logic        valid;
	logic        ready;
	logic        op;
	logic [7:0]  byte_value;
	logic [15:0] elapsed_ms;

	modport source (output valid, output op, output byte_value, output elapsed_ms,
		input ready);
	modport sink (input valid, input op, input byte_value, input elapsed_ms,
		output ready);
endinterface

interface spsg_out_if;
	import spsg_pkg::*;

	logic       valid;
	logic       ready;
	logic [1:0] response;
	logic [1:0] auth_state;

	modport source (output valid, output response, output auth_state, input ready);
	modport sink (input valid, input response, input auth_state, output ready);
endinterface

FILE: src/spsg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsg_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spsg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

FILE: src/spsg_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsg_alu
// Shared 32-bit unit: saturating add, greater-or-equal and equality compare.
// ----------------------------------------------------------------------------
module spsg_alu (
	input  spsg_pkg::alu_req_t req,
	output spsg_pkg::alu_rsp_t rsp
);
	import spsg_pkg::*;

	logic [32:0] sum;

	// saturating add and compares
	always_comb begin
		sum         = {1'b0, req.a} + {1'b0, req.b};
		rsp.sum_sat = sum[32] ? '1 : sum[31:0];
		rsp.ge      = (req.a >= req.b);
		rsp.eq      = (req.a == req.b);
	end
endmodule

FILE: src/spsg_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsg_seq
// Sequencer: timers, authentication state, command store walk and decode.
// ----------------------------------------------------------------------------
module spsg_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  spsg_pkg::cfg_t   cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  spsg_pkg::item_t  item,
	input  logic             out_free,
	output spsg_pkg::res_t   res
);
	import spsg_pkg::*;

	seq_state_t   state_q, state_d;
	guard_state_t guard_q, guard_d;
	logic [31:0]  sess_q, sess_d;
	logic [31:0]  auth_q, auth_d;
	logic [15:0]  ms_q, ms_d;
	logic [ADDR_W-1:0] fill_q, fill_d;
	logic [ADDR_W-1:0] pos_q, pos_d;
	logic         mism_q, mism_d;
	rsp_t         rsp_q, rsp_d;

	logic              ram_we;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [7:0]        ram_rdata;
	logic [ADDR_W-1:0] fill_next;
	logic [ADDR_W-1:0] idx;
	logic [3:0]        klen;
	logic              use_sess;
	logic [31:0]       timer_cur;
	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;

	spsg_ram #(
		.WIDTH (8),
		.DEPTH (BUFFER_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q),
		.wdata (item.byte_value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	spsg_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// helper values
	always_comb begin
		fill_next = (fill_q == ADDR_W'(BUFFER_DEPTH - 1)) ? '0 : fill_q + 1'b1;
		idx       = pos_q - 1'b1;
		klen      = (cfg.key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : cfg.key_length;
		use_sess  = (guard_q == ST_PASS);
		timer_cur = use_sess ? sess_q : auth_q;
	end

	// next state and outputs
	always_comb begin
		state_d   = state_q;
		guard_d   = guard_q;
		sess_d    = sess_q;
		auth_d    = auth_q;
		ms_d      = ms_q;
		fill_d    = fill_q;
		pos_d     = pos_q;
		mism_d    = mism_q;
		rsp_d     = rsp_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		alu_req.a = timer_cur;
		alu_req.b = {16'b0, ms_q};
		in_ready  = 1'b0;
		res.valid      = 1'b0;
		res.response   = rsp_q;
		res.auth_state = guard_q;

		case (state_q)
			SQ_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					rsp_d = RSP_NONE;
					if (item.op == OP_BYTE) begin
						ram_we  = 1'b1;
						fill_d  = fill_next;
						state_d = SQ_FINISH;
					end else begin
						ms_d = item.elapsed_ms;
						if (guard_q == ST_PASS || guard_q == ST_PROCESS) begin
							state_d = SQ_T_ADD;
						end else begin
							state_d = SQ_CHK;
						end
					end
				end
			end
			// running timer plus elapsed time, saturating
			SQ_T_ADD: begin
				if (use_sess) begin
					sess_d = alu_rsp.sum_sat;
				end else begin
					auth_d = alu_rsp.sum_sat;
				end
				state_d = SQ_T_CMP;
			end
			// timeout check ends the step when it fires
			SQ_T_CMP: begin
				alu_req.b = use_sess ? cfg.session_limit : cfg.auth_timeout;
				if (alu_rsp.ge) begin
					if (use_sess) begin
						guard_d = ST_NOT_REG;
					end else begin
						auth_d  = cfg.auth_timeout;
						guard_d = ST_FAIL;
					end
					state_d = SQ_FINISH;
				end else begin
					state_d = SQ_CHK;
				end
			end
			SQ_CHK: begin
				if (fill_q <= ADDR_W'(2)) begin
					state_d = SQ_FINISH;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = fill_q - ADDR_W'(2);
					state_d   = SQ_RD_CR;
				end
			end
			SQ_RD_CR: begin
				if (ram_rdata == CH_CR) begin
					ram_re    = 1'b1;
					ram_raddr = fill_q - 1'b1;
					state_d   = SQ_RD_LF;
				end else begin
					state_d = SQ_FINISH;
				end
			end
			SQ_RD_LF: begin
				if (ram_rdata == CH_LF) begin
					ram_re    = 1'b1;
					ram_raddr = '0;
					state_d   = SQ_RD_CMD;
				end else begin
					state_d = SQ_FINISH;
				end
			end
			// command decode, every command empties the store
			SQ_RD_CMD: begin
				fill_d  = '0;
				state_d = SQ_FINISH;
				case (ram_rdata)
					CMD_START: begin
						auth_d  = '0;
						guard_d = ST_PROCESS;
						rsp_d   = RSP_OK;
					end
					CMD_LOGOUT: begin
						guard_d = ST_NOT_REG;
						rsp_d   = RSP_OK;
					end
					CMD_REPLY: begin
						if (guard_q != ST_PROCESS) begin
							rsp_d = RSP_ERR;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = ADDR_W'(1);
							pos_d     = ADDR_W'(1);
							mism_d    = 1'b0;
							state_d   = SQ_PW;
						end
					end
					default: begin
						rsp_d = RSP_NONE;
					end
				endcase
			end
			// password walk, one stored byte per cycle up to CR or past the key length
			SQ_PW: begin
				alu_req.a = {24'b0, ram_rdata};
				alu_req.b = {24'b0, key_char(cfg.password_key, 3'(idx))};
				if (ram_rdata == CH_CR) begin
					if (CNT_W'(idx) == CNT_W'(klen) && !mism_q) begin
						sess_d  = '0;
						guard_d = ST_PASS;
						rsp_d   = RSP_OK;
					end else begin
						guard_d = ST_FAIL;
						rsp_d   = RSP_ERR;
					end
					state_d = SQ_FINISH;
				end else if (CNT_W'(idx) >= CNT_W'(klen)) begin
					guard_d = ST_FAIL;
					rsp_d   = RSP_ERR;
					state_d = SQ_FINISH;
				end else begin
					mism_d    = mism_q | ~alu_rsp.eq;
					pos_d     = pos_q + 1'b1;
					ram_re    = 1'b1;
					ram_raddr = pos_q + 1'b1;
				end
			end
			SQ_FINISH: begin
				if (out_free) begin
					res.valid = 1'b1;
					state_d   = SQ_IDLE;
				end
			end
			default: begin
				state_d = SQ_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// guard, timers and walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guard_q <= ST_NOT_REG;
			sess_q  <= '0;
			auth_q  <= '0;
			fill_q  <= '0;
			ms_q    <= '0;
			pos_q   <= '0;
			mism_q  <= 1'b0;
			rsp_q   <= RSP_NONE;
		end else begin
			guard_q <= guard_d;
			sess_q  <= sess_d;
			auth_q  <= auth_d;
			fill_q  <= fill_d;
			ms_q    <= ms_d;
			pos_q   <= pos_d;
			mism_q  <= mism_d;
			rsp_q   <= rsp_d;
		end
	end
endmodule

FILE: src/serial_password_session_guard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_password_session_guard
// Serial command guard with password check and session/authentication timers.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  in_ch    | in  | valid/ready   | op, byte_value, elapsed_ms
//  out_ch   | out | valid/ready   | response, auth_state
//  cfg      | in  | cfg_wr_en     | cfg_index, cfg_data (64 bit)
//
// A received byte is written to the store. A tick adds its elapsed time to
// the running timer while one runs; if that has not expired, it then reads
// the CR, LF and command bytes. A password command compares the stored bytes
// with the key, at most KEY_BYTES. Reset clears state and timers; the store
// contents stay unknown and need no clearing pass. A stalled result waits in
// the output register while the next transaction is taken and worked on.
// ----------------------------------------------------------------------------
module serial_password_session_guard (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	spsg_in_if.sink     in_ch,
	spsg_out_if.source  out_ch
);
	import spsg_pkg::*;

	cfg_t  cfg_q;
	item_t item;
	res_t  res;
	logic  out_free;
	logic  out_valid_q;
	rsp_t  out_rsp_q;
	guard_state_t out_state_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.session_limit <= SESSION_LIMIT_RST;
			cfg_q.auth_timeout  <= AUTH_TIMEOUT_RST;
			cfg_q.password_key  <= PASSWORD_KEY_RST;
			cfg_q.key_length    <= KEY_LENGTH_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_SESSION_LIMIT: cfg_q.session_limit <= cfg_data[31:0];
				CFG_AUTH_TIMEOUT:  cfg_q.auth_timeout  <= cfg_data[31:0];
				CFG_PASSWORD_KEY:  cfg_q.password_key  <= cfg_data;
				CFG_KEY_LENGTH:    cfg_q.key_length    <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// input transaction payload
	always_comb begin
		item.op         = op_t'(in_ch.op);
		item.byte_value = in_ch.byte_value;
		item.elapsed_ms = in_ch.elapsed_ms;
	end

	spsg_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.item     (item),
		.out_free (out_free),
		.res      (res)
	);

	// output register
	assign out_free = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_rsp_q   <= res.response;
			out_state_q <= res.auth_state;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.response   = out_rsp_q;
	assign out_ch.auth_state = out_state_q;
endmodule

FILE: src/spsg_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsg_chk
// Port-level checks for the serial password session guard.
// ----------------------------------------------------------------------------
module spsg_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] response,
	input logic [1:0] auth_state
);
	import spsg_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(response)
			&& $stable(auth_state))
		else $error("stalled result changed");

	// one transaction in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// response code is one of the three replies
	a_rsp_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> response == RSP_NONE || response == RSP_OK
			|| response == RSP_ERR)
		else $error("bad response code");

	// an OK reply never leaves the guard failed
	a_ok_not_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && response == RSP_OK |-> auth_state != ST_FAIL)
		else $error("OK reply with failed state");
endmodule

bind serial_password_session_guard spsg_chk u_spsg_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.response   (out_ch.response),
	.auth_state (out_ch.auth_state)
);

FILE: tb/sv/spsg_reply_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsg_reply_checker
// Watches the input and result channels of the serial password session
// guard, keeps its own copy of the guard state, timers, command store and
// registers, and checks every result transaction in order.
// ----------------------------------------------------------------------------
module spsg_reply_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	spsg_in_if          in_ch,
	spsg_out_if         out_ch,
	output int          pending,
	output int          fail_count,
	output int          results_checked,
	output int          ok_count,
	output int          err_count,
	output int          timeout_count
);
	import spsg_pkg::*;

	typedef struct packed {
		rsp_t         rsp;
		guard_state_t st;
	} guard_reply_t;

	// register copies
	logic [31:0]  session_limit;
	logic [31:0]  auth_limit;
	logic [63:0]  key_r;
	logic [3:0]   key_len_r;

	// guard state copies
	guard_state_t mode;
	logic [31:0]  session_ms;
	logic [31:0]  auth_ms;
	int           fill;
	logic [7:0]   store [BUFFER_DEPTH];

	guard_reply_t reply_q [$];

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	// advance the guard by one transaction and return the reply it gives
	function automatic guard_reply_t guard_step(input item_t it);
		guard_reply_t r;
		int           len;
		int           pos;
		int           i;
		bit           timed_out;
		bit           match;
		r.rsp = RSP_NONE;
		timed_out = 1'b0;
		if (it.op == OP_BYTE) begin
			store[fill] = it.byte_value;
			fill = (fill + 1) % BUFFER_DEPTH;
		end else begin
			// session timer only runs while passed
			if (mode == ST_PASS) begin
				session_ms = sat_add(session_ms, 32'(it.elapsed_ms));
				if (session_ms >= session_limit) begin
					mode = ST_NOT_REG;
					timed_out = 1'b1;
				end
			end
			// auth timer pins at its limit on expiry
			if (!timed_out && mode == ST_PROCESS) begin
				auth_ms = sat_add(auth_ms, 32'(it.elapsed_ms));
				if (auth_ms >= auth_limit) begin
					auth_ms = auth_limit;
					mode = ST_FAIL;
					timed_out = 1'b1;
				end
			end
			if (timed_out) begin
				timeout_count++;
			end else if (fill > 2 && store[fill-2] == CH_CR && store[fill-1] == CH_LF) begin
				case (store[0])
					CMD_START: begin
						auth_ms = '0;
						mode = ST_PROCESS;
						r.rsp = RSP_OK;
					end
					CMD_REPLY: begin
						if (mode != ST_PROCESS) begin
							r.rsp = RSP_ERR;
						end else begin
							// password runs from index 1 up to the first cr
							len = (key_len_r > KEY_BYTES) ? KEY_BYTES : int'(key_len_r);
							pos = 1;
							while (pos < fill && store[pos] != CH_CR)
								pos++;
							match = (pos - 1 == len);
							if (match) begin
								for (i = 0; i < len; i++)
									if (store[1+i] != key_r[8*(7-i) +: 8])
										match = 1'b0;
							end
							if (match) begin
								session_ms = '0;
								mode = ST_PASS;
								r.rsp = RSP_OK;
							end else begin
								mode = ST_FAIL;
								r.rsp = RSP_ERR;
							end
						end
					end
					CMD_LOGOUT: begin
						mode = ST_NOT_REG;
						r.rsp = RSP_OK;
					end
					default: ;
				endcase
				fill = 0;
			end
		end
		r.st = mode;
		return r;
	endfunction

	// track registers, predict on input transactions, compare on results
	always @(posedge clk or negedge arst_n) begin : watch
		guard_reply_t want;
		item_t        seen;
		if (!arst_n) begin
			session_limit = SESSION_LIMIT_RST;
			auth_limit = AUTH_TIMEOUT_RST;
			key_r = PASSWORD_KEY_RST;
			key_len_r = KEY_LENGTH_RST;
			mode = ST_NOT_REG;
			session_ms = '0;
			auth_ms = '0;
			fill = 0;
			reply_q.delete();
			pending = 0;
			fail_count = 0;
			results_checked = 0;
			ok_count = 0;
			err_count = 0;
			timeout_count = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_SESSION_LIMIT: session_limit = cfg_data[31:0];
					CFG_AUTH_TIMEOUT:  auth_limit = cfg_data[31:0];
					CFG_PASSWORD_KEY:  key_r = cfg_data;
					CFG_KEY_LENGTH:    key_len_r = cfg_data[3:0];
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				if (reply_q.size() == 0) begin
					$error("unexpected result transaction: response %0d, auth_state %0d",
						out_ch.response, out_ch.auth_state);
					fail_count++;
				end else begin
					want = reply_q.pop_front();
					results_checked++;
					if (want.rsp == RSP_OK)
						ok_count++;
					if (want.rsp == RSP_ERR)
						err_count++;
					if (out_ch.response !== want.rsp) begin
						$error("response mismatch: expected %0d, actual %0d",
							want.rsp, out_ch.response);
						fail_count++;
					end
					if (out_ch.auth_state !== want.st) begin
						$error("auth_state mismatch: expected %0d, actual %0d",
							want.st, out_ch.auth_state);
						fail_count++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				seen.op = op_t'(in_ch.op);
				seen.byte_value = in_ch.byte_value;
				seen.elapsed_ms = in_ch.elapsed_ms;
				reply_q.push_back(guard_step(seen));
			end
			pending = reply_q.size();
		end
	end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the serial password session guard with byte and tick transactions:
// a directed opening, random login, password, logout and noise sequences
// under several register settings, a long result stall, and a session timer
// run up to its exact limit. Checking is done by spsg_reply_checker.
// ----------------------------------------------------------------------------
module testbench;
	import spsg_pkg::*;

	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 50;
	localparam int PHASE_ITEMS    = 70;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;

	spsg_in_if  in_ch ();
	spsg_out_if out_ch ();

	bit          no_idle;
	bit          hold_req;
	int          pending;
	int          fail_count;
	int          results_checked;
	int          ok_count;
	int          err_count;
	int          timeout_count;
	int          items_sent = 0;
	int          settings_used = 1;
	int          idle_cycles = 0;
	logic [63:0] cur_key;
	logic [3:0]  cur_len;
	logic [7:0]  line_q [$];

	always #6 clk = ~clk;

	serial_password_session_guard u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	spsg_reply_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_ch           (in_ch),
		.out_ch          (out_ch),
		.pending         (pending),
		.fail_count      (fail_count),
		.results_checked (results_checked),
		.ok_count        (ok_count),
		.err_count       (err_count),
		.timeout_count   (timeout_count)
	);

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || cfg_wr_en || (in_ch.valid && in_ch.ready) ||
			(out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", idle_cycles);
			$display("simulation failed");
			$finish;
		end
	end

	// result side: random stalls, one long hold-off on request
	initial begin : result_sink
		int stall;
		out_ch.ready = 1'b0;
		forever begin
			if (hold_req) begin
				stall = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				stall = no_idle ? 0 : $urandom_range(0, 8);
			end
			repeat (stall) begin
				@(negedge clk);
				out_ch.ready = 1'b0;
			end
			@(negedge clk);
			out_ch.ready = 1'b1;
			do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
		end
	end

	task automatic send_item(input op_t op, input logic [7:0] b, input logic [15:0] ms);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		repeat (gap) begin
			@(negedge clk);
			in_ch.valid = 1'b0;
		end
		@(negedge clk);
		in_ch.valid = 1'b1;
		in_ch.op = op;
		in_ch.byte_value = b;
		in_ch.elapsed_ms = ms;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(OP_BYTE, b, 16'($urandom));
	endtask

	task automatic send_tick(input logic [15:0] ms);
		send_item(OP_TICK, 8'($urandom), ms);
	endtask

	// mostly short ticks, sometimes extremes or anything
	function automatic logic [15:0] rand_ms();
		case ($urandom_range(0, 9))
			0:       return 16'd0;
			1:       return 16'hFFFF;
			2, 3:    return 16'($urandom);
			default: return 16'($urandom_range(0, 50));
		endcase
	endfunction

	// line buffer followed by cr lf
	task automatic send_line();
		int i;
		for (i = 0; i < line_q.size(); i++)
			send_byte(line_q[i]);
		send_byte(CH_CR);
		send_byte(CH_LF);
	endtask

	task automatic login();
		line_q.delete();
		line_q.push_back(CMD_START);
		send_line();
		send_tick(rand_ms());
	endtask

	// password line: 0 correct, 1 one char off, 2 short, 3 long, 4 garbage
	task automatic try_password(input int flaw);
		int eff;
		int i;
		int k;
		eff = (cur_len > KEY_BYTES) ? KEY_BYTES : int'(cur_len);
		line_q.delete();
		line_q.push_back(CMD_REPLY);
		for (i = 0; i < eff; i++)
			line_q.push_back(cur_key[8*(7-i) +: 8]);
		case (flaw)
			1: begin
				if (eff > 0) begin
					k = $urandom_range(1, eff);
					line_q[k] = line_q[k] ^ 8'($urandom_range(1, 255));
				end else begin
					line_q.push_back(8'($urandom));
				end
			end
			2: if (eff > 0) void'(line_q.pop_back());
			3: line_q.push_back(8'($urandom));
			4: begin
				line_q.delete();
				line_q.push_back(CMD_REPLY);
				repeat ($urandom_range(0, 10)) line_q.push_back(8'($urandom));
			end
			default: ;
		endcase
		send_line();
	endtask

	function automatic int pick_flaw();
		return ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 4);
	endfunction

	// stop offering and wait for every result
	task automatic pause_input();
		@(negedge clk);
		in_ch.valid = 1'b0;
		wait (pending == 0);
	endtask

	task automatic drain();
		pause_input();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input cfg_idx_t idx, input logic [63:0] data);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic set_config(input logic [31:0] sess, input logic [31:0] auth,
		input logic [63:0] key, input logic [3:0] len);
		cfg_write(CFG_SESSION_LIMIT, 64'(sess));
		cfg_write(CFG_AUTH_TIMEOUT, 64'(auth));
		cfg_write(CFG_PASSWORD_KEY, key);
		cfg_write(CFG_KEY_LENGTH, 64'(len));
		cur_key = key;
		cur_len = len;
		settings_used++;
	endtask

	// random command traffic until n more transactions went in
	task automatic run_random(input int n);
		int target;
		int pick;
		target = items_sent + n;
		while (items_sent < target) begin
			pick = $urandom_range(0, 99);
			no_idle = ($urandom_range(0, 7) == 0);
			if (pick < 30) begin
				login();
				try_password(pick_flaw());
				send_tick(rand_ms());
			end else if (pick < 42) begin
				try_password(pick_flaw());
				send_tick(rand_ms());
			end else if (pick < 52) begin
				line_q.delete();
				line_q.push_back(CMD_LOGOUT);
				repeat ($urandom_range(0, 2)) line_q.push_back(8'($urandom));
				send_line();
				send_tick(rand_ms());
			end else if (pick < 67) begin
				repeat ($urandom_range(1, 3)) send_tick(rand_ms());
			end else if (pick < 77) begin
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
				send_tick(rand_ms());
			end else if (pick < 84) begin
				// mostly unknown commands
				line_q.delete();
				line_q.push_back(8'($urandom));
				repeat ($urandom_range(0, 3)) line_q.push_back(8'($urandom));
				send_line();
				send_tick(rand_ms());
			end else if (pick < 89) begin
				// broken terminators
				send_byte($urandom_range(0, 1) ? CMD_START : CMD_LOGOUT);
				if ($urandom_range(0, 1)) begin
					send_byte(CH_LF);
					send_byte(CH_CR);
				end else begin
					send_byte(CH_CR);
				end
				send_tick(rand_ms());
			end else if (pick < 93) begin
				// long runs wrap the command store
				repeat ($urandom_range(30, 40)) send_byte(8'($urandom));
				if ($urandom_range(0, 1)) begin
					send_byte(CH_CR);
					send_byte(CH_LF);
				end
				send_tick(rand_ms());
			end else if (pick < 98) begin
				// password waiting in the store across a possible auth timeout
				login();
				try_password(pick_flaw());
				send_tick(16'hFFFF);
				send_tick(16'd0);
			end else begin
				pause_input();
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.op = OP_BYTE;
		in_ch.byte_value = '0;
		in_ch.elapsed_ms = '0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_SESSION_LIMIT;
		cfg_data = '0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		cur_key = PASSWORD_KEY_RST;
		cur_len = KEY_LENGTH_RST;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed opening at reset register values
		send_tick(16'd0);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(CH_CR);
		send_byte(CH_LF);
		send_tick(16'hFFFF);
		line_q.delete();
		line_q.push_back(CMD_REPLY);
		send_line();
		send_tick(16'd0);
		line_q.delete();
		line_q.push_back(CMD_START);
		send_line();
		send_tick(16'd1);
		try_password(0);
		send_tick(16'd0);
		line_q.delete();
		line_q.push_back(CMD_LOGOUT);
		send_line();
		send_tick(16'd0);
		drain();

		// result side holds off while the sender keeps offering
		hold_req = 1'b1;
		no_idle = 1'b1;
		repeat (16) send_tick(rand_ms());
		no_idle = 1'b0;
		drain();

		// random traffic under several register settings
		set_config(32'd1, 32'd1, {$urandom, $urandom}, 4'($urandom_range(1, 8)));
		run_random(PHASE_ITEMS);
		drain();
		set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0, 4'd0);
		run_random(PHASE_ITEMS);
		drain();
		set_config(32'd50000, 32'd20000, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
		run_random(PHASE_ITEMS);
		drain();
		set_config(32'($urandom_range(1, 200000)), 32'($urandom_range(1, 100000)),
			{$urandom, $urandom}, 4'd1);
		run_random(PHASE_ITEMS);
		drain();
		set_config($urandom, $urandom, {$urandom, $urandom}, 4'($urandom_range(0, 15)));
		run_random(PHASE_ITEMS);
		drain();
		set_config(SESSION_LIMIT_RST, AUTH_TIMEOUT_RST, PASSWORD_KEY_RST, KEY_LENGTH_RST);
		run_random(PHASE_ITEMS);
		drain();

		// session timer walked in full-size ticks, expiring exactly at its limit
		set_config(32'h0004_0000, 32'hFFFF_FFFF, PASSWORD_KEY_RST, KEY_LENGTH_RST);
		no_idle = 1'b1;
		login();
		try_password(0);
		send_tick(16'd0);
		repeat (4) send_tick(16'hFFFF);
		send_tick(16'd4);
		no_idle = 1'b0;
		drain();

		$display("covered: %0d transactions in, %0d results checked, %0d register settings",
			items_sent, results_checked, settings_used);
		$display("replies: %0d ok, %0d err, %0d timer expiries incl. an exact session limit",
			ok_count, err_count, timeout_count);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: filelist.f
src/spsg_pkg.sv
src/spsg_if.sv
src/spsg_ram.sv
src/spsg_alu.sv
src/spsg_seq.sv
src/serial_password_session_guard.sv
src/spsg_chk.sv
tb/sv/spsg_reply_checker.sv
tb/sv/testbench.sv
